// ----- src/iqmh_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and defaults for the indexed quaternary min-heap.
package iqmh_pkg;

	localparam int DEF_CAPACITY = 256;
	localparam int DEF_NODE_IDS = 1024;
	localparam int DEF_KEY_BITS = 64;

	// four children per slot: child = 4s+1.., parent = (s-1)/4
	localparam int ARITY_SHIFT = 2;
	localparam int ARITY = 1 << ARITY_SHIFT;

	localparam int NODE_W = 10;
	localparam int KEY_W = 64;
	localparam int LIMIT_W = 9;
	localparam int COUNT_W = 9;
	localparam int QUEUE_DEPTH = 2;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_EMPTY = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	typedef struct packed {
		op_t op;
		logic node_ok;
		logic [NODE_W-1:0] node;
		logic [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		status_t status;
		logic [NODE_W-1:0] taken_node;
		logic [KEY_W-1:0] taken_key;
		logic top_valid;
		logic [NODE_W-1:0] top_node;
		logic [KEY_W-1:0] top_key;
		logic [COUNT_W-1:0] count;
	} res_t;

endpackage

// ----- src/iqmh_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module iqmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ----- src/iqmh_fifo.sv -----
`timescale 1ns / 1ps
// Small register FIFO used for the request and result queues.
module iqmh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop = pop & ~empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end
endmodule

// ----- src/iqmh_front.sv -----
`timescale 1ns / 1ps
// Front end: takes requests, classifies them and queues them for the engine.
module iqmh_front #(
	parameter int NODE_IDS = iqmh_pkg::DEF_NODE_IDS,
	parameter int KEY_BITS = iqmh_pkg::DEF_KEY_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  logic [1:0]                  mode,
	input  logic [iqmh_pkg::NODE_W-1:0] node_id,
	input  logic [iqmh_pkg::KEY_W-1:0]  key,
	input  logic                        hold,
	output logic                        full,
	input  logic                        req_pop,
	output iqmh_pkg::req_t              req,
	output logic                        req_empty
);
	import iqmh_pkg::*;

	localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);

	req_t req_in;
	logic q_full;
	logic [$bits(req_t)-1:0] q_rdata;

	always_comb begin
		req_in.op = op_t'(mode);
		req_in.node_ok = (32'(node_id) < NODE_IDS);
		req_in.node = node_id;
		req_in.key = key & KEY_MASK;
	end

	// no intake while the engine sweeps the position table
	assign full = q_full | hold;
	assign req = q_rdata;

	iqmh_fifo #(
		.WIDTH($bits(req_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_req_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(push & ~full),
		.wdata(req_in),
		.full(q_full),
		.pop(req_pop),
		.rdata(q_rdata),
		.empty(req_empty)
	);
endmodule

// ----- src/iqmh_back.sv -----
`timescale 1ns / 1ps
// Heap engine: position lookup, sift up and sift down over the slot and position RAMs.
module iqmh_back #(
	parameter int CAPACITY = iqmh_pkg::DEF_CAPACITY,
	parameter int NODE_IDS = iqmh_pkg::DEF_NODE_IDS,
	parameter int KEY_BITS = iqmh_pkg::DEF_KEY_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [iqmh_pkg::LIMIT_W-1:0] cfg_limit,
	input  logic                         req_empty,
	input  iqmh_pkg::req_t               req,
	output logic                         req_pop,
	input  logic                         res_full,
	output logic                         res_push,
	output iqmh_pkg::res_t               res,
	output logic                         clearing
);
	import iqmh_pkg::*;

	localparam int SLOT_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int NID_W = $clog2(NODE_IDS);
	localparam int EXT_W = SLOT_W + ARITY_SHIFT + 1;
	localparam int J_W = $clog2(ARITY + 1);
	localparam int HW = NODE_W + KEY_BITS;
	localparam int PW = 1 + SLOT_W;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_PRD    = 10'b0000000100,
		S_LRD    = 10'b0000001000,
		S_RISE   = 10'b0000010000,
		S_RISE_W = 10'b0000100000,
		S_SINK   = 10'b0001000000,
		S_SCAN   = 10'b0010000000,
		S_PLACE  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [NID_W-1:0] clr_q, clr_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [LIMIT_W-1:0] limit_q;

	op_t op_q, op_d;
	status_t status_q, status_d;
	logic [NODE_W-1:0] item_node_q, item_node_d;
	logic [KEY_BITS-1:0] item_key_q, item_key_d;
	logic [SLOT_W-1:0] slot_q, slot_d;
	logic moved_q, moved_d;
	logic taken_q, taken_d;
	logic [NODE_W-1:0] taken_node_q, taken_node_d;
	logic [KEY_BITS-1:0] taken_key_q, taken_key_d;
	logic [NODE_W-1:0] best_node_q, best_node_d;
	logic [KEY_BITS-1:0] best_key_q, best_key_d;
	logic [SLOT_W-1:0] best_slot_q, best_slot_d;
	logic [J_W-1:0] j_q, j_d;
	logic [NODE_W-1:0] root_node_q;
	logic [KEY_BITS-1:0] root_key_q;

	logic h_we;
	logic [SLOT_W-1:0] h_waddr, h_raddr;
	logic [HW-1:0] h_wdata, h_rdata;
	logic p_we;
	logic [NID_W-1:0] p_waddr, p_raddr;
	logic [PW-1:0] p_wdata, p_rdata;

	logic [NODE_W-1:0] rd_node;
	logic [KEY_BITS-1:0] rd_key;
	logic p_present;
	logic [SLOT_W-1:0] p_slot;
	logic [CNT_W-1:0] last;
	logic at_limit;
	logic [SLOT_W-1:0] parent_slot;
	logic [EXT_W-1:0] first_ext, next_ext, child_ext;
	logic take;
	logic [NODE_W-1:0] nb_node;
	logic [KEY_BITS-1:0] nb_key;
	logic [SLOT_W-1:0] nb_slot;

	assign rd_node = h_rdata[HW-1:KEY_BITS];
	assign rd_key = h_rdata[KEY_BITS-1:0];
	assign p_present = p_rdata[PW-1];
	assign p_slot = p_rdata[SLOT_W-1:0];
	assign last = count_q - CNT_W'(1);
	assign at_limit = (32'(count_q) >= 32'(limit_q)) || (32'(count_q) >= CAPACITY);
	assign parent_slot = (slot_q - SLOT_W'(1)) >> ARITY_SHIFT;
	assign first_ext = EXT_W'({slot_q, {ARITY_SHIFT{1'b0}}}) + EXT_W'(1);
	assign next_ext = first_ext + EXT_W'(j_q);
	assign child_ext = next_ext - EXT_W'(1);

	// running minimum over the children, first child always taken
	assign take = (j_q == J_W'(1)) || (rd_key < best_key_q);
	assign nb_node = take ? rd_node : best_node_q;
	assign nb_key = take ? rd_key : best_key_q;
	assign nb_slot = take ? child_ext[SLOT_W-1:0] : best_slot_q;

	assign clearing = (state_q == S_CLEAR);

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		count_d = count_q;
		op_d = op_q;
		status_d = status_q;
		item_node_d = item_node_q;
		item_key_d = item_key_q;
		slot_d = slot_q;
		moved_d = moved_q;
		taken_d = taken_q;
		taken_node_d = taken_node_q;
		taken_key_d = taken_key_q;
		best_node_d = best_node_q;
		best_key_d = best_key_q;
		best_slot_d = best_slot_q;
		j_d = j_q;
		h_we = 1'b0;
		h_waddr = slot_q;
		h_wdata = {item_node_q, item_key_q};
		h_raddr = '0;
		p_we = 1'b0;
		p_waddr = NID_W'(item_node_q);
		p_wdata = {1'b1, slot_q};
		p_raddr = NID_W'(req.node);
		req_pop = 1'b0;
		res_push = 1'b0;

		unique case (state_q)
			S_CLEAR: begin
				p_we = 1'b1;
				p_waddr = clr_q;
				p_wdata = '0;
				clr_d = clr_q + NID_W'(1);
				if (clr_q == NID_W'(NODE_IDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (!req_empty && !res_full) begin
					req_pop = 1'b1;
					op_d = req.op;
					item_node_d = req.node;
					item_key_d = req.key[KEY_BITS-1:0];
					status_d = ST_OK;
					taken_d = 1'b0;
					moved_d = 1'b0;
					unique case (req.op)
						OP_INSERT: begin
							if (!req.node_ok) begin
								status_d = ST_ABSENT;
								state_d = S_DONE;
							end else begin
								state_d = S_PRD;
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								state_d = S_DONE;
							end else if (!req.node_ok) begin
								status_d = ST_ABSENT;
								state_d = S_DONE;
							end else begin
								state_d = S_PRD;
							end
						end
						OP_EXTRACT: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								state_d = S_DONE;
							end else begin
								// root is slot 0, no lookup needed
								taken_d = 1'b1;
								taken_node_d = root_node_q;
								taken_key_d = root_key_q;
								p_we = 1'b1;
								p_waddr = NID_W'(root_node_q);
								p_wdata = '0;
								slot_d = '0;
								count_d = last;
								if (last == '0) begin
									state_d = S_DONE;
								end else begin
									h_raddr = last[SLOT_W-1:0];
									state_d = S_LRD;
								end
							end
						end
						default: begin
							state_d = S_DONE;
						end
					endcase
				end
			end
			S_PRD: begin
				if (op_q == OP_INSERT) begin
					if (p_present) begin
						slot_d = p_slot;
						state_d = S_RISE;
					end else if (at_limit) begin
						status_d = ST_FULL;
						state_d = S_DONE;
					end else begin
						slot_d = count_q[SLOT_W-1:0];
						count_d = count_q + CNT_W'(1);
						state_d = S_RISE;
					end
				end else if (!p_present) begin
					status_d = ST_ABSENT;
					state_d = S_DONE;
				end else begin
					p_we = 1'b1;
					p_wdata = '0;
					slot_d = p_slot;
					count_d = last;
					if (CNT_W'(p_slot) == last) begin
						state_d = S_DONE;
					end else begin
						h_raddr = last[SLOT_W-1:0];
						state_d = S_LRD;
					end
				end
			end
			S_LRD: begin
				// last entry refills the hole
				item_node_d = rd_node;
				item_key_d = rd_key;
				state_d = S_RISE;
			end
			S_RISE: begin
				if (slot_q == '0) begin
					state_d = moved_q ? S_PLACE : S_SINK;
				end else begin
					h_raddr = parent_slot;
					state_d = S_RISE_W;
				end
			end
			S_RISE_W: begin
				if (item_key_q < rd_key) begin
					h_we = 1'b1;
					h_wdata = h_rdata;
					p_we = 1'b1;
					p_waddr = NID_W'(rd_node);
					slot_d = parent_slot;
					moved_d = 1'b1;
					state_d = S_RISE;
				end else begin
					state_d = moved_q ? S_PLACE : S_SINK;
				end
			end
			S_SINK: begin
				if (first_ext >= EXT_W'(count_q)) begin
					state_d = S_PLACE;
				end else begin
					h_raddr = first_ext[SLOT_W-1:0];
					j_d = J_W'(1);
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				best_node_d = nb_node;
				best_key_d = nb_key;
				best_slot_d = nb_slot;
				if (j_q < J_W'(ARITY) && next_ext < EXT_W'(count_q)) begin
					h_raddr = next_ext[SLOT_W-1:0];
					j_d = j_q + J_W'(1);
				end else if (nb_key >= item_key_q) begin
					state_d = S_PLACE;
				end else begin
					h_we = 1'b1;
					h_wdata = {nb_node, nb_key};
					p_we = 1'b1;
					p_waddr = NID_W'(nb_node);
					slot_d = nb_slot;
					state_d = S_SINK;
				end
			end
			S_PLACE: begin
				h_we = 1'b1;
				p_we = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				res_push = 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			count_q <= '0;
			limit_q <= LIMIT_RESET;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			count_q <= count_d;
			if (cfg_we) begin
				limit_q <= cfg_limit;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;
		status_q <= status_d;
		item_node_q <= item_node_d;
		item_key_q <= item_key_d;
		slot_q <= slot_d;
		moved_q <= moved_d;
		taken_q <= taken_d;
		taken_node_q <= taken_node_d;
		taken_key_q <= taken_key_d;
		best_node_q <= best_node_d;
		best_key_q <= best_key_d;
		best_slot_q <= best_slot_d;
		j_q <= j_d;
		// root copy follows every write to slot 0
		if (h_we && h_waddr == '0) begin
			root_node_q <= h_wdata[HW-1:KEY_BITS];
			root_key_q <= h_wdata[KEY_BITS-1:0];
		end
	end

	always_comb begin
		res.status = status_q;
		res.taken_node = taken_q ? taken_node_q : '0;
		res.taken_key = taken_q ? KEY_W'(taken_key_q) : '0;
		res.top_valid = (count_q != '0);
		res.top_node = (count_q != '0) ? root_node_q : '0;
		res.top_key = (count_q != '0) ? KEY_W'(root_key_q) : '0;
		res.count = COUNT_W'(count_q);
	end

	iqmh_ram #(
		.WIDTH(HW),
		.DEPTH(CAPACITY)
	) u_slot_ram (
		.clk(clk),
		.we(h_we),
		.waddr(h_waddr),
		.wdata(h_wdata),
		.raddr(h_raddr),
		.rdata(h_rdata)
	);

	iqmh_ram #(
		.WIDTH(PW),
		.DEPTH(NODE_IDS)
	) u_pos_ram (
		.clk(clk),
		.we(p_we),
		.waddr(p_waddr),
		.wdata(p_wdata),
		.raddr(p_raddr),
		.rdata(p_rdata)
	);
endmodule

// ----- src/indexed_quaternary_min_heap.sv -----
`timescale 1ns / 1ps
// Top level of the indexed quaternary min-heap: front end, engine and result queue.
//
//   channel   | handshake           | payload
//   ----------+---------------------+------------------------------------------------
//   request   | push / full         | mode, node_id, key
//   result    | pop / empty         | status, taken_node, taken_key, top_valid,
//             |                     | top_node, top_key, count
//   config    | capacity_limit_we   | capacity_limit
//
// One request at a time in the engine. A refused request, a no-op or an extract that
// empties the heap needs no sift; a sift adds lookup, refill and write-back, plus a
// parent read and compare per level sifted up and up to four child reads per level
// sifted down (one child read per cycle on the single read port of the slot RAM).
// After reset the position table is swept, one entry a cycle, with full held high.
// Two-entry queues on each side absorb stalls.
module indexed_quaternary_min_heap #(
	parameter int CAPACITY = iqmh_pkg::DEF_CAPACITY,
	parameter int NODE_IDS = iqmh_pkg::DEF_NODE_IDS,
	parameter int KEY_BITS = iqmh_pkg::DEF_KEY_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [1:0]                   mode,
	input  logic [iqmh_pkg::NODE_W-1:0]  node_id,
	input  logic [iqmh_pkg::KEY_W-1:0]   key,
	output logic                         full,
	input  logic                         pop,
	output logic                         empty,
	output logic [1:0]                   status,
	output logic [iqmh_pkg::NODE_W-1:0]  taken_node,
	output logic [iqmh_pkg::KEY_W-1:0]   taken_key,
	output logic                         top_valid,
	output logic [iqmh_pkg::NODE_W-1:0]  top_node,
	output logic [iqmh_pkg::KEY_W-1:0]   top_key,
	output logic [iqmh_pkg::COUNT_W-1:0] count,
	input  logic                         capacity_limit_we,
	input  logic [iqmh_pkg::LIMIT_W-1:0] capacity_limit
);
	import iqmh_pkg::*;

	req_t req;
	logic req_empty, req_pop;
	logic clearing;
	res_t res_in, res_out;
	logic res_push, res_full;
	logic [$bits(res_t)-1:0] res_rdata;

	iqmh_front #(
		.NODE_IDS(NODE_IDS),
		.KEY_BITS(KEY_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.mode(mode),
		.node_id(node_id),
		.key(key),
		.hold(clearing),
		.full(full),
		.req_pop(req_pop),
		.req(req),
		.req_empty(req_empty)
	);

	iqmh_back #(
		.CAPACITY(CAPACITY),
		.NODE_IDS(NODE_IDS),
		.KEY_BITS(KEY_BITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(capacity_limit_we),
		.cfg_limit(capacity_limit),
		.req_empty(req_empty),
		.req(req),
		.req_pop(req_pop),
		.res_full(res_full),
		.res_push(res_push),
		.res(res_in),
		.clearing(clearing)
	);

	iqmh_fifo #(
		.WIDTH($bits(res_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.wdata(res_in),
		.full(res_full),
		.pop(pop),
		.rdata(res_rdata),
		.empty(empty)
	);

	assign res_out = res_rdata;
	assign status = res_out.status;
	assign taken_node = res_out.taken_node;
	assign taken_key = res_out.taken_key;
	assign top_valid = res_out.top_valid;
	assign top_node = res_out.top_node;
	assign top_key = res_out.top_key;
	assign count = res_out.count;

`ifndef ASSERT_OFF
	// the sweep must finish before any request reaches the engine
	a_clear_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req_pop)
		else $error("request taken during position table sweep");

	// a request only starts with room for its result
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into full queue");

	a_top_count: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (top_valid == (count != '0)))
		else $error("top_valid disagrees with count");

	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> full)
		else $error("intake open during sweep");
`endif
endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the indexed quaternary min-heap.
module tb;
	import iqmh_pkg::*;

	localparam int HEAP_SLOTS = 256;
	localparam int NODE_COUNT = 1024;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [1:0] mode = OP_NONE;
	logic [NODE_W-1:0] node_id = '0;
	logic [KEY_W-1:0] key = '0;
	logic full;
	logic pop = 1'b0;
	logic empty;
	logic [1:0] status;
	logic [NODE_W-1:0] taken_node;
	logic [KEY_W-1:0] taken_key;
	logic top_valid;
	logic [NODE_W-1:0] top_node;
	logic [KEY_W-1:0] top_key;
	logic [COUNT_W-1:0] count;
	logic capacity_limit_we = 1'b0;
	logic [LIMIT_W-1:0] capacity_limit = LIMIT_RESET;

	indexed_quaternary_min_heap dut (
		.clk(clk), .arst_n(arst_n), .push(push), .mode(mode), .node_id(node_id),
		.key(key), .full(full), .pop(pop), .empty(empty), .status(status),
		.taken_node(taken_node), .taken_key(taken_key), .top_valid(top_valid),
		.top_node(top_node), .top_key(top_key), .count(count),
		.capacity_limit_we(capacity_limit_we), .capacity_limit(capacity_limit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow heap
	logic [NODE_W-1:0] sh_node [HEAP_SLOTS];
	logic [KEY_W-1:0] sh_key [HEAP_SLOTS];
	int unsigned sh_pos [NODE_COUNT];
	bit sh_present [NODE_COUNT];
	int unsigned sh_count;
	int unsigned sh_limit;

	res_t expected_results[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned send_idle = 0;
	int unsigned recv_idle = 0;

	function automatic void put(int unsigned s, logic [NODE_W-1:0] n, logic [KEY_W-1:0] k);
		sh_node[s] = n;
		sh_key[s] = k;
		sh_pos[n] = s;
	endfunction

	function automatic void float_up(int unsigned s);
		logic [NODE_W-1:0] n;
		logic [KEY_W-1:0] k;
		int unsigned hole, up;
		if (s >= sh_count) return;
		n = sh_node[s];
		k = sh_key[s];
		hole = s;
		while (hole > 0) begin
			up = (hole - 1) / ARITY;
			if (k < sh_key[up]) begin
				put(hole, sh_node[up], sh_key[up]);
				hole = up;
			end else break;
		end
		put(hole, n, k);
	endfunction

	function automatic void float_down(int unsigned s);
		logic [NODE_W-1:0] n;
		logic [KEY_W-1:0] k, best_key;
		int unsigned hole, first, best;
		if (s >= sh_count) return;
		n = sh_node[s];
		k = sh_key[s];
		hole = s;
		forever begin
			first = ARITY * hole + 1;
			if (first >= sh_count) break;
			best = first;
			best_key = sh_key[first];
			for (int unsigned c = first + 1; c < first + ARITY && c < sh_count; c++)
				if (sh_key[c] < best_key) begin
					best_key = sh_key[c];
					best = c;
				end
			if (best_key >= k) break;
			put(hole, sh_node[best], best_key);
			hole = best;
		end
		put(hole, n, k);
	endfunction

	function automatic status_t remove_node(logic [NODE_W-1:0] n);
		int unsigned s, last;
		if (sh_count == 0) return ST_EMPTY;
		if (!sh_present[n]) return ST_ABSENT;
		s = sh_pos[n];
		sh_present[n] = 1'b0;
		last = sh_count - 1;
		if (s == last) begin
			sh_count = last;
			return ST_OK;
		end
		put(s, sh_node[last], sh_key[last]);
		sh_count = last;
		float_up(s);
		float_down(s);
		return ST_OK;
	endfunction

	function automatic res_t heap_step(op_t op, logic [NODE_W-1:0] n, logic [KEY_W-1:0] k);
		res_t r;
		int unsigned lim;
		r = '0;
		r.status = ST_OK;
		case (op)
			OP_INSERT: begin
				lim = sh_limit < HEAP_SLOTS ? sh_limit : HEAP_SLOTS;
				if (sh_present[n]) begin
					sh_key[sh_pos[n]] = k;
					float_up(sh_pos[n]);
					float_down(sh_pos[n]);
				end else if (sh_count >= lim) r.status = ST_FULL;
				else begin
					sh_present[n] = 1'b1;
					sh_count++;
					put(sh_count - 1, n, k);
					float_up(sh_count - 1);
				end
			end
			OP_EXTRACT: begin
				if (sh_count == 0) r.status = ST_EMPTY;
				else begin
					r.taken_node = sh_node[0];
					r.taken_key = sh_key[0];
					void'(remove_node(sh_node[0]));
				end
			end
			OP_DELETE: r.status = remove_node(n);
			default: ;
		endcase
		if (sh_count > 0) begin
			r.top_valid = 1'b1;
			r.top_node = sh_node[0];
			r.top_key = sh_key[0];
		end
		r.count = sh_count[COUNT_W-1:0];
		return r;
	endfunction

	// request driver; results are predicted as each request is accepted
	task automatic send_request(op_t op, logic [NODE_W-1:0] n, logic [KEY_W-1:0] k,
			bit fixed, res_t known);
		res_t r;
		while (send_idle != 0 && $urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		mode <= op;
		node_id <= n;
		key <= k;
		@(posedge clk);
		while (full) @(posedge clk);
		r = heap_step(op, n, k);
		expected_results.push_back(fixed ? known : r);
	endtask

	task automatic set_limit(int unsigned v);
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		capacity_limit_we <= 1'b1;
		capacity_limit <= v[LIMIT_W-1:0];
		@(posedge clk);
		capacity_limit_we <= 1'b0;
		sh_limit = v;
	endtask

	// receive and compare
	always @(posedge clk) begin
		res_t got, want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = '{status_t'(status), taken_node, taken_key, top_valid, top_node,
					top_key, count};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", got);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected %p got %p", want, got);
					end
				end
			end
			pop <= !(recv_idle != 0 && $urandom_range(99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("indexed_quaternary_min_heap verification failed");
			$finish;
		end
	end

	typedef struct {
		op_t op;
		logic [NODE_W-1:0] n;
		logic [KEY_W-1:0] k;
		bit fixed;
		res_t known;
	} stim_row_t;

	stim_row_t directed [] = '{
		'{OP_EXTRACT, 10'd0, 64'd0, 1'b1, '{ST_EMPTY, 10'd0, 64'd0, 1'b0, 10'd0, 64'd0, 9'd0}},
		'{OP_DELETE, 10'd5, 64'd0, 1'b1, '{ST_EMPTY, 10'd0, 64'd0, 1'b0, 10'd0, 64'd0, 9'd0}},
		'{OP_NONE, 10'h3ff, '1, 1'b1, '{ST_OK, 10'd0, 64'd0, 1'b0, 10'd0, 64'd0, 9'd0}},
		'{OP_INSERT, 10'h3ff, '1, 1'b1, '{ST_OK, 10'd0, 64'd0, 1'b1, 10'h3ff, '1, 9'd1}},
		'{OP_INSERT, 10'd0, 64'd0, 1'b1, '{ST_OK, 10'd0, 64'd0, 1'b1, 10'd0, 64'd0, 9'd2}},
		'{OP_DELETE, 10'd7, 64'd0, 1'b1, '{ST_ABSENT, 10'd0, 64'd0, 1'b1, 10'd0, 64'd0, 9'd2}},
		'{OP_INSERT, 10'd21, 64'h5555_5555_5555_5555, 1'b0, '0},
		'{OP_INSERT, 10'd42, 64'haaaa_aaaa_aaaa_aaaa, 1'b0, '0},
		'{OP_INSERT, 10'd0, 64'h8000_0000_0000_0000, 1'b0, '0},
		'{OP_INSERT, 10'h3ff, 64'd1, 1'b0, '0},
		'{OP_INSERT, 10'd300, 64'd1, 1'b0, '0},
		'{OP_INSERT, 10'd301, 64'd7, 1'b0, '0},
		'{OP_INSERT, 10'd302, 64'd3, 1'b0, '0},
		'{OP_DELETE, 10'd21, 64'd0, 1'b0, '0},
		'{OP_EXTRACT, 10'd0, 64'd0, 1'b0, '0},
		'{OP_EXTRACT, 10'd0, 64'd0, 1'b0, '0},
		'{OP_DELETE, 10'd42, 64'd0, 1'b0, '0},
		'{OP_EXTRACT, 10'd0, 64'd0, 1'b0, '0},
		'{OP_EXTRACT, 10'd0, 64'd0, 1'b0, '0},
		'{OP_EXTRACT, 10'd0, 64'd0, 1'b0, '0},
		'{OP_EXTRACT, 10'd0, 64'd0, 1'b1, '{ST_EMPTY, 10'd0, 64'd0, 1'b0, 10'd0, 64'd0, 9'd0}}
	};

	// random request; a small pool of ids keeps updates and deletes hitting present nodes
	task automatic random_request(int unsigned pool);
		int unsigned pick;
		logic [NODE_W-1:0] n;
		logic [KEY_W-1:0] k;
		op_t op;
		pick = $urandom_range(99);
		op = pick < 55 ? OP_INSERT : pick < 75 ? OP_EXTRACT : pick < 95 ? OP_DELETE : OP_NONE;
		n = $urandom_range(9) == 0 ? NODE_W'($urandom) : NODE_W'($urandom_range(pool - 1));
		case ($urandom_range(3))
			0: k = {$urandom, $urandom};
			1: k = KEY_W'($urandom_range(15));
			2: k = ~KEY_W'($urandom_range(15));
			default: k = {$urandom, 32'd0} | KEY_W'($urandom_range(3));
		endcase
		send_request(op, n, k, 1'b0, '0);
	endtask

	initial begin
		int unsigned limits [6] = '{256, 1, 3, 0, 17, 511};
		sh_count = 0;
		sh_limit = 256;
		for (int i = 0; i < NODE_COUNT; i++) sh_present[i] = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed[i])
			send_request(directed[i].op, directed[i].n, directed[i].k,
				directed[i].fixed, directed[i].known);
		// full heap, update while full, then a limit below the count
		set_limit(3);
		for (int i = 0; i < 5; i++) send_request(OP_INSERT, NODE_W'(i + 100), KEY_W'(50 - i),
			1'b0, '0);
		send_request(OP_INSERT, 10'd101, 64'd1, 1'b0, '0);
		set_limit(1);
		send_request(OP_INSERT, 10'd900, 64'd2, 1'b0, '0);
		for (int p = 0; p < 6; p++) begin
			set_limit(limits[p]);
			send_idle = p < 2 ? 25 : p < 4 ? 71 : 0;
			recv_idle = p < 2 ? 71 : p < 4 ? 25 : 0;
			for (int i = 0; i < 88; i++)
				random_request(p == 5 ? 1024 : p == 0 ? 300 : 24);
		end
		send_idle = 0;
		push <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (mismatches == 0) $display("indexed_quaternary_min_heap verification clean");
		else $display("indexed_quaternary_min_heap verification failed");
		$finish;
	end

	final begin end
endmodule
